// File: rtl/i2ew_pkg.sv
// Shared constants and types for the integer-to-English-words block.
`default_nettype none

package i2ew_pkg;

  // Width of the value field on the input channel.
  localparam int unsigned VALUE_W        = 31;
  // Default number of value bits that take part in the conversion.
  localparam int unsigned VALUE_BITS_DEF = 31;
  // Decimal digits needed for the widest value.
  localparam int unsigned NUM_DIGITS     = 10;
  // Three-digit groups: billions, millions, thousands, units.
  localparam int unsigned NUM_GROUPS     = 4;
  localparam int unsigned GRP_W          = $clog2(NUM_GROUPS);
  // Entries in the queue between converter and word sequencer.
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned WORD_W         = 5;

  typedef logic [3:0]        digit_t;
  typedef logic [WORD_W-1:0] word_t;

  // One converted number as packed decimal digits, least significant first.
  typedef struct packed {
    digit_t [NUM_DIGITS-1:0] digit;
  } bcd_t;

  // Word codes.
  localparam word_t W_ZERO     = 5'd0;
  localparam word_t W_TEN      = 5'd10;
  localparam word_t W_TWENTY   = 5'd20;
  localparam word_t W_HUNDRED  = 5'd28;
  localparam word_t W_THOUSAND = 5'd29;
  localparam word_t W_MILLION  = 5'd30;
  localparam word_t W_BILLION  = 5'd31;

  // Group indexes, most significant first.
  localparam logic [GRP_W-1:0] GRP_BILLION  = 2'd0;
  localparam logic [GRP_W-1:0] GRP_MILLION  = 2'd1;
  localparam logic [GRP_W-1:0] GRP_THOUSAND = 2'd2;
  localparam logic [GRP_W-1:0] GRP_UNITS    = 2'd3;

  // Word sequencer steps within one group.
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_HUND,
    SEQ_HWORD,
    SEQ_TENS,
    SEQ_UNITS,
    SEQ_SCALE
  } seq_e;

endpackage

`default_nettype wire

// File: rtl/i2ew_if.sv
// Channel interfaces for the input numbers and the output words.
`default_nettype none

interface i2ew_in_if;
  logic                            valid;
  logic                            ready;
  logic [i2ew_pkg::VALUE_W-1:0]    value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface i2ew_out_if;
  logic                            valid;
  logic                            ready;
  logic [i2ew_pkg::WORD_W-1:0]     word_code;
  logic                            last_word;

  modport source (output valid, output word_code, output last_word, input ready);
  modport sink   (input valid, input word_code, input last_word, output ready);
endinterface

`default_nettype wire

// File: rtl/i2ew_front.sv
// Front end: accepts a number and converts it to decimal digits, two bits per cycle.
`default_nettype none

module i2ew_front #(
  parameter int unsigned VALUE_BITS = i2ew_pkg::VALUE_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [i2ew_pkg::VALUE_W-1:0] in_value_i,
  output logic                              push_valid_o,
  input  wire logic                         push_ready_i,
  output i2ew_pkg::bcd_t                    push_data_o
);

  localparam int unsigned ITERS = (VALUE_BITS + 1) / 2;
  localparam int unsigned SR_W  = 2 * ITERS;
  localparam int unsigned CNT_W = $clog2(ITERS + 1);

  // One shift-and-add-three step of the binary to decimal conversion.
  function automatic i2ew_pkg::bcd_t dabble(i2ew_pkg::bcd_t b, logic bit_in);
    i2ew_pkg::bcd_t a;
    a = b;
    for (int i = 0; i < int'(i2ew_pkg::NUM_DIGITS); i++) begin
      if (a.digit[i] >= 4'd5) begin
        a.digit[i] = a.digit[i] + 4'd3;
      end
    end
    return i2ew_pkg::bcd_t'({a[i2ew_pkg::NUM_DIGITS*4-2:0], bit_in});
  endfunction

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [SR_W-1:0]    sr_q;
  i2ew_pkg::bcd_t     bcd_q;
  i2ew_pkg::bcd_t     bcd_step;
  logic               accept;

  // Handshakes: a new number may enter as the finished one leaves.
  always_comb begin
    in_ready_o   = !busy_q && (!done_q || push_ready_i);
    accept       = in_valid_i && in_ready_o;
    push_valid_o = done_q;
    push_data_o  = bcd_q;
    bcd_step     = dabble(dabble(bcd_q, sr_q[SR_W-1]), sr_q[SR_W-2]);
  end

  // Control: count the conversion steps and hold the result until the queue takes it.
  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    if (done_q && push_ready_i) begin
      done_d = 1'b0;
    end
    if (accept) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(ITERS);
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath: the binary shift register feeds the digit register MSB first.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sr_q  <= SR_W'(in_value_i[VALUE_BITS-1:0]);
      bcd_q <= '0;
    end else if (busy_q) begin
      sr_q  <= {sr_q[SR_W-3:0], 2'b00};
      bcd_q <= bcd_step;
    end
  end

endmodule

`default_nettype wire

// File: rtl/i2ew_queue.sv
// Small queue of converted numbers between the front end and the word sequencer.
`default_nettype none

module i2ew_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_valid_i,
  output logic                 push_ready_o,
  input  wire i2ew_pkg::bcd_t  push_data_i,
  output logic                 pop_valid_o,
  input  wire logic            pop_ready_i,
  output i2ew_pkg::bcd_t       pop_data_o
);

  localparam int unsigned DEPTH = i2ew_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  i2ew_pkg::bcd_t    mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;
  logic              do_push, do_pop;

  always_comb begin
    push_ready_o = (count_q != CNT_W'(DEPTH));
    pop_valid_o  = (count_q != '0);
    pop_data_o   = mem_q[rd_ptr_q];
    do_push      = push_valid_i && push_ready_o;
    do_pop       = pop_valid_o && pop_ready_i;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/i2ew_back.sv
// Back end: walks one number's digit groups word by word, then takes the next.
`default_nettype none

module i2ew_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        pop_valid_i,
  output logic                             pop_ready_o,
  input  wire i2ew_pkg::bcd_t              pop_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [i2ew_pkg::WORD_W-1:0]      out_word_code_o,
  output logic                             out_last_word_o
);

  localparam int unsigned NG    = i2ew_pkg::NUM_GROUPS;
  localparam int unsigned GRP_W = i2ew_pkg::GRP_W;

  i2ew_pkg::seq_e              state_q, state_d, nxt;
  logic [GRP_W-1:0]            grp_q, grp_d;
  i2ew_pkg::bcd_t              cur_q;
  logic                        load;

  logic                        oval_q, oval_d;
  i2ew_pkg::word_t             code_q;
  logic                        last_q;

  i2ew_pkg::digit_t [3*NG-1:0] ext;
  logic [NG-1:0]               nz;
  i2ew_pkg::digit_t            h, t, u;
  logic                        later;
  logic                        e_hund, e_tens, e_units, e_scale;
  logic                        e_cur, emit, out_free, pop_zero, wrap;
  i2ew_pkg::word_t             code, scale_code;
  logic                        last;

  // Digit groups of the current number and which of them are non-zero.
  always_comb begin
    ext = '0;
    ext[i2ew_pkg::NUM_DIGITS-1:0] = cur_q.digit;
    for (int k = 0; k < int'(NG); k++) begin
      nz[k] = (ext[3*(NG-1-k)+2] != '0) || (ext[3*(NG-1-k)+1] != '0) ||
              (ext[3*(NG-1-k)] != '0);
    end
    later = 1'b0;
    for (int k = 0; k < int'(NG); k++) begin
      if (GRP_W'(k) > grp_q) begin
        later = later | nz[k];
      end
    end
  end

  // Digits of the group being spelled.
  always_comb begin
    unique case (grp_q)
      i2ew_pkg::GRP_BILLION: begin
        h = ext[11]; t = ext[10]; u = ext[9];
        scale_code = i2ew_pkg::W_BILLION;
      end
      i2ew_pkg::GRP_MILLION: begin
        h = ext[8]; t = ext[7]; u = ext[6];
        scale_code = i2ew_pkg::W_MILLION;
      end
      i2ew_pkg::GRP_THOUSAND: begin
        h = ext[5]; t = ext[4]; u = ext[3];
        scale_code = i2ew_pkg::W_THOUSAND;
      end
      default: begin
        h = ext[2]; t = ext[1]; u = ext[0];
        scale_code = i2ew_pkg::W_THOUSAND;
      end
    endcase
    e_hund  = (h != '0);
    e_tens  = (t != '0);
    e_units = (t != 4'd1) && (u != '0);
    e_scale = nz[grp_q] && (grp_q != i2ew_pkg::GRP_UNITS);
  end

  // Sequencer: next step, word to emit and whether it ends the spelling.
  always_comb begin
    out_free    = !oval_q || out_ready_i;
    pop_zero    = (pop_data_i == '0);
    wrap        = (grp_q == GRP_W'(NG - 1));
    state_d     = state_q;
    grp_d       = grp_q;
    nxt         = state_q;
    pop_ready_o = 1'b0;
    load        = 1'b0;
    e_cur       = 1'b0;
    emit        = 1'b0;
    code        = i2ew_pkg::W_ZERO;
    last        = 1'b0;
    unique case (state_q)
      i2ew_pkg::SEQ_IDLE: begin
        if (pop_valid_i) begin
          if (pop_zero) begin
            if (out_free) begin
              emit        = 1'b1;
              last        = 1'b1;
              pop_ready_o = 1'b1;
            end
          end else begin
            pop_ready_o = 1'b1;
            load        = 1'b1;
            grp_d       = '0;
            state_d     = i2ew_pkg::SEQ_HUND;
          end
        end
      end
      i2ew_pkg::SEQ_HUND: begin
        e_cur = e_hund;
        code  = i2ew_pkg::word_t'(h);
        nxt   = i2ew_pkg::SEQ_HWORD;
      end
      i2ew_pkg::SEQ_HWORD: begin
        e_cur = e_hund;
        code  = i2ew_pkg::W_HUNDRED;
        last  = !(e_tens || e_units || e_scale || later);
        nxt   = i2ew_pkg::SEQ_TENS;
      end
      i2ew_pkg::SEQ_TENS: begin
        e_cur = e_tens;
        if (t == 4'd1) begin
          code = i2ew_pkg::W_TEN + i2ew_pkg::word_t'(u);
        end else begin
          code = i2ew_pkg::W_TWENTY + i2ew_pkg::word_t'(t) - i2ew_pkg::word_t'(2);
        end
        last  = !(e_units || e_scale || later);
        nxt   = i2ew_pkg::SEQ_UNITS;
      end
      i2ew_pkg::SEQ_UNITS: begin
        e_cur = e_units;
        code  = i2ew_pkg::word_t'(u);
        last  = !(e_scale || later);
        nxt   = i2ew_pkg::SEQ_SCALE;
      end
      i2ew_pkg::SEQ_SCALE: begin
        e_cur = e_scale;
        code  = scale_code;
        last  = !later;
        nxt   = wrap ? i2ew_pkg::SEQ_IDLE : i2ew_pkg::SEQ_HUND;
      end
      default: begin
        state_d = i2ew_pkg::SEQ_IDLE;
      end
    endcase
    // A step with a word waits for a free output slot; an empty step just moves on.
    if (state_q != i2ew_pkg::SEQ_IDLE) begin
      emit = e_cur && out_free;
      if (!e_cur || out_free) begin
        state_d = nxt;
        if (state_q == i2ew_pkg::SEQ_SCALE && !wrap) begin
          grp_d = grp_q + 1'b1;
        end
      end
    end
    oval_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : oval_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= i2ew_pkg::SEQ_IDLE;
      grp_q   <= '0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      grp_q   <= grp_d;
      oval_q  <= oval_d;
    end
  end

  // Number being spelled and the output register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= pop_data_i;
    end
    if (emit) begin
      code_q <= code;
      last_q <= last;
    end
  end

  assign out_valid_o     = oval_q;
  assign out_word_code_o = code_q;
  assign out_last_word_o = last_q;

endmodule

`default_nettype wire

// File: rtl/integer_to_english_words.sv
// Top level of the integer-to-English-words block.
// Each accepted number is spelled as a run of word transactions, most significant
// word first, with last_word set on the final one; zero gives the single word Zero.
// The front end converts the number to decimal, two bits per cycle, and hands the
// digits through a two-entry queue to the word sequencer. The sequencer walks five
// steps for each of the four digit groups plus one to load a non-zero number, and
// it sets the sustained rate. The front end converts the next number while words
// still flow.
`default_nettype none

module integer_to_english_words #(
  parameter int unsigned VALUE_BITS = i2ew_pkg::VALUE_BITS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  i2ew_in_if.sink     in_i,
  i2ew_out_if.source  out_o
);

  logic            push_valid, push_ready;
  i2ew_pkg::bcd_t  push_data;
  logic            pop_valid, pop_ready;
  i2ew_pkg::bcd_t  pop_data;

  // Binary to decimal conversion.
  i2ew_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .in_value_i   (in_i.value),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // Decoupling queue.
  i2ew_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Word sequencer and output register.
  i2ew_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pop_valid_i     (pop_valid),
    .pop_ready_o     (pop_ready),
    .pop_data_i      (pop_data),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .out_word_code_o (out_o.word_code),
    .out_last_word_o (out_o.last_word)
  );

endmodule

`default_nettype wire

// File: rtl/i2ew_checker.sv
// Port-level checks for the integer-to-English-words block and their binding.
`default_nettype none

module i2ew_checker (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         out_valid_i,
  input  wire logic                         out_ready_i,
  input  wire logic [i2ew_pkg::WORD_W-1:0]  out_word_code_i,
  input  wire logic                         out_last_word_i
);

  // No word is offered in the cycle after reset is seen.
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("word offered during reset");

  // A stalled word stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("word withdrawn while stalled");

  // A Zero word always carries last_word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_word_code_i == i2ew_pkg::W_ZERO) |-> out_last_word_i)
    else $error("Zero word not marked last");

  // Hundred is never followed at once by another Hundred.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && out_word_code_i == i2ew_pkg::W_HUNDRED) |=>
    !(out_valid_i && out_word_code_i == i2ew_pkg::W_HUNDRED))
    else $error("Hundred repeated");

endmodule

bind integer_to_english_words i2ew_checker u_i2ew_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_word_code_i (out_o.word_code),
  .out_last_word_i (out_o.last_word)
);

`default_nettype wire
